// ===== sv/tplc_pkg.sv =====
// Package with the shared types and constants of the two-point calibration unit.
`timescale 1ns / 1ps
package tplc_pkg;

  localparam int TARGET_COUNT_DEF  = 4;
  localparam int VALUE_BITS_DEF    = 48;
  localparam int FRACTION_BITS_DEF = 16;

  // Multiplier digit consumed per cycle.
  localparam int DIGIT_BITS = 8;

  localparam int DEFAULT_REGS = 4;
  localparam logic [63:0] GAIN_RESET [DEFAULT_REGS] = '{
    64'd69905, 64'd1258271, 64'd983040000, 64'd54613333
  };

  typedef enum logic [1:0] {
    ACT_APPLY  = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_COMMIT = 2'd2,
    ACT_RESET  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD     = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_DEGEN   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MSET,
    S_MUL,
    S_MRND,
    S_DIV,
    S_DFIN,
    S_FIN,
    S_DONE
  } state_t;

endpackage

// ===== sv/two_point_linear_calibration_unit.sv =====
// Top level of the two-point gain and offset calibration unit.
`timescale 1ns / 1ps
// Each item names a target and an action. Apply returns gain*x+offset in signed
// fixed point, record stores one of the two points of a target, commit fits the
// line through both points and reset loads the target's default gain. Items are
// handled one at a time. Record, reset and any item with a bad target go straight to
// the output register; a commit that fails stops after the memory read; apply runs
// the digit-serial multiplier and rounds, and a successful commit runs the restoring
// divider that forms the gain, then the multiplier for the offset. A new item is taken
// while the previous result waits in the output register. Gain, offset and the x and y
// points each live in a memory of their own; all are read into registers as the item
// is accepted. Default gain writes take effect on the next reset action.
module two_point_linear_calibration_unit
  import tplc_pkg::*;
#(
  parameter int TARGET_COUNT  = TARGET_COUNT_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // target, point_index, x_value, y_value, zero fill
  input  logic [((2*VALUE_BITS+4+7)/8)*8-1:0] s_tdata,
  // action
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // result_value, zero fill
  output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
  // status, calibrated
  output logic [2:0] m_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);

  localparam int VB  = VALUE_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int TC  = TARGET_COUNT;
  localparam int TAW = (TC > 1) ? $clog2(TC) : 1;
  localparam int PAW = $clog2(2*TC);
  localparam int ND  = (VB + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MB  = ND * DIGIT_BITS;
  localparam int NB  = VB + 1 + FB;
  localparam int DB  = VB + 1;
  localparam int CW  = $clog2(NB + 1);
  localparam int PW  = 2*VB + 1;
  localparam int SW  = 2*VB + 2;
  localparam int ODW = ((VB+7)/8)*8;

  localparam logic [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FB-1);

  state_t state, state_next;

  // Input unpacking.
  action_t in_action;
  logic [2:0] in_target;
  logic in_pidx;
  logic [VB-1:0] in_x, in_y;
  logic in_accept, in_bad;

  assign in_action = action_t'(s_tuser);
  assign in_target = s_tdata[2:0];
  assign in_pidx   = s_tdata[3];
  assign in_x      = s_tdata[4 +: VB];
  assign in_y      = s_tdata[4+VB +: VB];
  assign in_accept = s_tvalid && s_tready;
  assign in_bad    = ({1'b0, in_target} >= 4'(TC));

  // Memories.
  logic [VB-1:0] gain_mem [TC];
  logic [VB-1:0] off_mem  [TC];
  logic [VB-1:0] px_mem   [2*TC];
  logic [VB-1:0] py_mem   [2*TC];

  logic [TC-1:0]   cal_valid;
  logic [2*TC-1:0] point_present;
  logic            calibrated;
  logic [VB-1:0]   default_gain [DEFAULT_REGS];

  // Item registers.
  action_t act;
  logic [2:0] tgt;
  logic [VB-1:0] x_r;
  logic [VB-1:0] rd_gain, rd_off, rd_x0, rd_x1, rd_y0, rd_y1;
  logic gv, pv0, pv1;
  logic [VB-1:0] op_a, op_b, gain_r;
  logic [VB-1:0] ma;
  logic [MB-1:0] mb;
  logic mneg;
  logic [2*MB-1:0] acc;
  logic [CW-1:0] cnt;
  logic signed [PW-1:0] prod_r;
  logic [NB-1:0] num_q;
  logic [DB-1:0] rem, den;
  logic qneg;
  logic [VB-1:0] res_value;
  status_t res_status;

  // Combinational datapath pieces.
  logic [VB-1:0] gain_eff, off_eff, abs_a, abs_b;
  logic signed [DB-1:0] dx, dy;
  logic [DB-1:0] abs_dx, abs_dy;
  logic [DB:0] rs;
  logic rs_ge;
  logic [NB:0] q1;
  logic q_over;
  logic [VB-1:0] gain_sat;
  logic signed [PW-1:0] pm;
  logic signed [SW-1:0] fsum;
  logic [SW-VB:0] fhi;
  logic [VB-1:0] fsat;

  always_comb begin
    gain_eff = gv ? rd_gain : VB'(GAIN_RESET[tgt[1:0]]);
    off_eff  = gv ? rd_off : '0;
    abs_a    = op_a[VB-1] ? (~op_a + 1'b1) : op_a;
    abs_b    = op_b[VB-1] ? (~op_b + 1'b1) : op_b;
    dx       = $signed({rd_x1[VB-1], rd_x1}) - $signed({rd_x0[VB-1], rd_x0});
    dy       = $signed({rd_y1[VB-1], rd_y1}) - $signed({rd_y0[VB-1], rd_y0});
    abs_dx   = dx[DB-1] ? DB'(-dx) : DB'(dx);
    abs_dy   = dy[DB-1] ? DB'(-dy) : DB'(dy);
    rs       = {rem, num_q[NB-1]};
    rs_ge    = (rs >= {1'b0, den});
    q1       = {1'b0, num_q} + (NB+1)'(({rem, 1'b0} >= {1'b0, den}));
    if (qneg) begin
      q_over   = (|q1[NB:VB]) || (q1[VB-1] && (|q1[VB-2:0]));
      gain_sat = q_over ? VMIN : (~q1[VB-1:0] + 1'b1);
    end else begin
      q_over   = |q1[NB:VB-1];
      gain_sat = q_over ? VMAX : q1[VB-1:0];
    end
    pm = $signed(PW'(acc[2*VB-1:0]));
    if (act == ACT_COMMIT) begin
      fsum = $signed(SW'($signed(rd_y0))) - $signed(SW'(prod_r));
    end else begin
      fsum = $signed(SW'(prod_r)) + $signed(SW'($signed(off_eff)));
    end
    fhi = fsum[SW-1:VB-1];
    if (fsum[SW-1] && !(&fhi)) begin
      fsat = VMIN;
    end else if (!fsum[SW-1] && (|fhi)) begin
      fsat = VMAX;
    end else begin
      fsat = fsum[VB-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (in_bad || in_action == ACT_RECORD || in_action == ACT_RESET) begin
            state_next = S_DONE;
          end else begin
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (act == ACT_APPLY) begin
          state_next = S_MSET;
        end else if (pv0 && pv1 && rd_x0 != rd_x1) begin
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MSET: state_next = S_MUL;
      S_MUL:  if (cnt == '0) state_next = S_MRND;
      S_MRND: state_next = S_FIN;
      S_DIV:  if (cnt == '0) state_next = S_DFIN;
      S_DFIN: state_next = S_MSET;
      S_FIN:  state_next = S_DONE;
      S_DONE: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready  = (state == S_IDLE);
    cfg_ready = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      cal_valid     <= '0;
      point_present <= '0;
      calibrated    <= 1'b0;
      for (int i = 0; i < DEFAULT_REGS; i++) begin
        default_gain[i] <= VB'(GAIN_RESET[i]);
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        default_gain[cfg_index] <= cfg_data;
      end
      if (in_accept && !in_bad && in_action == ACT_RECORD) begin
        point_present[PAW'({in_target, in_pidx})] <= 1'b1;
      end
      if (in_accept && !in_bad && in_action == ACT_RESET) begin
        cal_valid[TAW'(in_target)] <= 1'b1;
      end
      if (state == S_FIN && act == ACT_COMMIT) begin
        cal_valid[TAW'(tgt)] <= 1'b1;
        calibrated <= 1'b1;
      end
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Memories and datapath.
  always_ff @(posedge clk) begin
    if (in_accept && !in_bad && in_action == ACT_RECORD) begin
      px_mem[PAW'({in_target, in_pidx})] <= in_x;
      py_mem[PAW'({in_target, in_pidx})] <= in_y;
    end
    if (in_accept && !in_bad && in_action == ACT_RESET) begin
      gain_mem[TAW'(in_target)] <= default_gain[in_target[1:0]];
      off_mem[TAW'(in_target)]  <= '0;
    end else if (state == S_FIN && act == ACT_COMMIT) begin
      gain_mem[TAW'(tgt)] <= gain_r;
      off_mem[TAW'(tgt)]  <= fsat;
    end

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          act     <= in_action;
          tgt     <= in_target;
          x_r     <= in_x;
          rd_gain <= gain_mem[TAW'(in_target)];
          rd_off  <= off_mem[TAW'(in_target)];
          rd_x0   <= px_mem[PAW'({in_target, 1'b0})];
          rd_x1   <= px_mem[PAW'({in_target, 1'b1})];
          rd_y0   <= py_mem[PAW'({in_target, 1'b0})];
          rd_y1   <= py_mem[PAW'({in_target, 1'b1})];
          gv      <= cal_valid[TAW'(in_target)];
          pv0     <= point_present[PAW'({in_target, 1'b0})];
          pv1     <= point_present[PAW'({in_target, 1'b1})];
          if (in_bad) begin
            res_status <= STAT_BAD;
            res_value  <= (in_action == ACT_APPLY) ? in_x : '0;
          end else begin
            res_status <= STAT_OK;
            res_value  <= '0;
          end
        end
      end
      S_LOAD: begin
        op_a  <= gain_eff;
        op_b  <= x_r;
        den   <= abs_dx;
        num_q <= NB'(abs_dy) << FB;
        rem   <= '0;
        qneg  <= dx[DB-1] ^ dy[DB-1];
        cnt   <= CW'(NB - 1);
        if (act == ACT_COMMIT) begin
          if (!(pv0 && pv1)) begin
            res_status <= STAT_MISSING;
          end else if (rd_x0 == rd_x1) begin
            res_status <= STAT_DEGEN;
          end
        end
      end
      S_MSET: begin
        ma   <= abs_a;
        mb   <= MB'(abs_b);
        mneg <= op_a[VB-1] ^ op_b[VB-1];
        acc  <= '0;
        cnt  <= CW'(ND - 1);
      end
      S_MUL: begin
        acc <= (acc << DIGIT_BITS) + (2*MB)'(ma * mb[MB-1 -: DIGIT_BITS]);
        mb  <= mb << DIGIT_BITS;
        cnt <= cnt - 1'b1;
      end
      S_MRND: begin
        prod_r <= ((mneg ? -pm : pm) + HALF) >>> FB;
      end
      S_DIV: begin
        rem   <= rs_ge ? DB'(rs - {1'b0, den}) : DB'(rs);
        num_q <= {num_q[NB-2:0], rs_ge};
        cnt   <= cnt - 1'b1;
      end
      S_DFIN: begin
        gain_r <= gain_sat;
        op_a   <= gain_sat;
        op_b   <= rd_x0;
      end
      S_FIN: begin
        if (act == ACT_APPLY) begin
          res_value <= fsat;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= ODW'(res_value);
          m_tuser <= {calibrated, res_status};
        end
      end
      default: ;
    endcase
  end

endmodule
